// File: rtl/core/cbm_pkg.sv
// Shared types and constants for the cartridge bank mapper.
// Command word passed from the decoder to the page unit, address map, codes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package cbm_pkg;

  // Update kinds reported on the result channel
  localparam logic [1:0] KIND_NONE   = 2'd0;
  localparam logic [1:0] KIND_PRG    = 2'd1;
  localparam logic [1:0] KIND_CHR    = 2'd2;
  localparam logic [1:0] KIND_MIRROR = 2'd3;

  // Input operation codes
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_TICK  = 1'b1;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_PRG_SIZE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CHR_SIZE = 2'd1;

  // Bus address map
  localparam logic [15:0] ADDR_PRG0    = 16'h8000;
  localparam logic [15:0] ADDR_MIRROR  = 16'hB003;
  localparam logic [15:0] ADDR_PRG2    = 16'hC000;
  localparam logic [15:0] ADDR_CHR_LO  = 16'hD000;
  localparam logic [15:0] ADDR_CHR_LOE = 16'hD003;
  localparam logic [15:0] ADDR_CHR_HI  = 16'hE000;
  localparam logic [15:0] ADDR_CHR_HIE = 16'hE003;
  localparam logic [15:0] ADDR_IRQ_LAT = 16'hF000;
  localparam logic [15:0] ADDR_IRQ_EN  = 16'hF001;
  localparam logic [15:0] ADDR_IRQ_CTL = 16'hF002;

  // Mirroring control codes (low seven bits of the byte)
  localparam logic [6:0] MIR_MASK     = 7'h7F;
  localparam logic [6:0] MIR_CODE_U0  = 7'h08;
  localparam logic [6:0] MIR_CODE_U1  = 7'h2C;
  localparam logic [6:0] MIR_CODE_V   = 7'h20;
  localparam logic [6:0] MIR_CODE_H   = 7'h24;
  localparam logic [6:0] MIR_CODE_L   = 7'h28;
  localparam logic [7:0] MIR_HORIZ    = 8'd0;
  localparam logic [7:0] MIR_VERT     = 8'd1;
  localparam logic [7:0] MIR_UPPER    = 8'd2;
  localparam logic [7:0] MIR_LOWER    = 8'd3;

  // Scanline counter threshold
  localparam logic [7:0] IRQ_LIMIT = 8'hFE;

  // Page unit: modulus width, value width and remainder step counter width
  localparam int unsigned MOD_W    = 11;
  localparam int unsigned VAL_W    = 8;
  localparam int unsigned STEP_W   = 3;

  // Command queue
  localparam int unsigned Q_DEPTH = 2;
  localparam int unsigned Q_AW    = 1;

  typedef struct packed {
    logic [1:0]       kind;
    logic [2:0]       slot;
    logic [VAL_W-1:0] value;
    logic [MOD_W-1:0] modulus;
    logic             reduce;
    logic             irq;
  } cmd_t;

  // Character slot permutation
  function automatic logic [2:0] chr_slot(input logic [2:0] idx);
    logic [2:0] s;
    case (idx)
      3'd0:    s = 3'd0;
      3'd1:    s = 3'd2;
      3'd2:    s = 3'd1;
      3'd3:    s = 3'd3;
      3'd4:    s = 3'd4;
      3'd5:    s = 3'd6;
      3'd6:    s = 3'd5;
      3'd7:    s = 3'd7;
      default: s = 3'd0;
    endcase
    return s;
  endfunction

endpackage
`default_nettype wire

// File: rtl/core/cbm_front.sv
// Front end: accepts input words, decodes bus writes, runs the scanline counter.
// Holds the size registers and emits one cmd_t per word. Depends on cbm_pkg.
`timescale 1ns / 1ps
`default_nettype none
module cbm_front (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic                          in_op,
  input  wire logic [15:0]                   in_addr,
  input  wire logic [7:0]                    in_data,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [cbm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [7:0]                    cfg_data,
  input  wire logic                          q_full,
  output logic                               push,
  output cbm_pkg::cmd_t                      push_cmd
);
  import cbm_pkg::*;

  logic [7:0] prg_size_r, prg_size_nxt;
  logic [7:0] chr_size_r, chr_size_nxt;
  logic [7:0] irq_cnt_r, irq_cnt_nxt;
  logic [7:0] irq_lat_r, irq_lat_nxt;
  logic [1:0] irq_en_r, irq_en_nxt;
  logic [MOD_W-1:0] prg_mod;
  logic [MOD_W-1:0] chr_mod;
  logic [6:0] mir_code;
  cmd_t cmd;

  assign in_ready  = !q_full;
  assign cfg_ready = 1'b1;
  assign push      = in_valid && in_ready;
  assign push_cmd  = cmd;

  assign prg_mod  = {2'b00, prg_size_r, 1'b0};
  assign chr_mod  = {chr_size_r, 3'b000};
  assign mir_code = in_data[6:0] & MIR_MASK;

  // Decode the word and compute next counter state
  always_comb begin
    cmd          = '0;
    prg_size_nxt = prg_size_r;
    chr_size_nxt = chr_size_r;
    irq_cnt_nxt  = irq_cnt_r;
    irq_lat_nxt  = irq_lat_r;
    irq_en_nxt   = irq_en_r;

    if (in_op == OP_TICK) begin
      if (irq_en_r != 2'b00) begin
        if (irq_cnt_r >= IRQ_LIMIT) begin
          cmd.irq     = 1'b1;
          irq_cnt_nxt = irq_lat_r;
          irq_en_nxt  = 2'b00;
        end else begin
          irq_cnt_nxt = irq_cnt_r + 8'd1;
        end
      end
    end else if (in_addr == ADDR_PRG0) begin
      cmd.kind    = KIND_PRG;
      cmd.slot    = 3'd0;
      cmd.value   = {in_data[6:0], 1'b0};
      cmd.modulus = prg_mod;
      cmd.reduce  = (prg_mod != '0);
    end else if (in_addr == ADDR_PRG2) begin
      cmd.kind    = KIND_PRG;
      cmd.slot    = 3'd2;
      cmd.value   = in_data;
      cmd.modulus = prg_mod;
      cmd.reduce  = (prg_mod != '0);
    end else if (in_addr inside {[ADDR_CHR_LO:ADDR_CHR_LOE], [ADDR_CHR_HI:ADDR_CHR_HIE]}) begin
      cmd.kind    = KIND_CHR;
      cmd.slot    = chr_slot({in_addr >= ADDR_CHR_HI, in_addr[1:0]});
      cmd.value   = in_data;
      cmd.modulus = chr_mod;
      cmd.reduce  = (chr_mod != '0);
    end else if (in_addr == ADDR_MIRROR) begin
      case (mir_code)
        MIR_CODE_U0, MIR_CODE_U1: begin
          cmd.kind  = KIND_MIRROR;
          cmd.value = MIR_UPPER;
        end
        MIR_CODE_V: begin
          cmd.kind  = KIND_MIRROR;
          cmd.value = MIR_VERT;
        end
        MIR_CODE_H: begin
          cmd.kind  = KIND_MIRROR;
          cmd.value = MIR_HORIZ;
        end
        MIR_CODE_L: begin
          cmd.kind  = KIND_MIRROR;
          cmd.value = MIR_LOWER;
        end
        default: begin
          cmd.kind = KIND_NONE;
        end
      endcase
    end else if (in_addr == ADDR_IRQ_LAT) begin
      irq_lat_nxt = in_data;
    end else if (in_addr == ADDR_IRQ_EN) begin
      irq_en_nxt = {1'b0, in_data[0]};
    end else if (in_addr == ADDR_IRQ_CTL) begin
      irq_en_nxt = in_data[1:0];
      if (in_data[1]) begin
        irq_cnt_nxt = irq_lat_r;
      end
    end

    // Size registers; the user must write them only while idle, which this block does not enforce
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_PRG_SIZE: prg_size_nxt = cfg_data;
        CFG_CHR_SIZE: chr_size_nxt = cfg_data;
        default:      ;
      endcase
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prg_size_r <= 8'd2;
      chr_size_r <= 8'd0;
      irq_cnt_r  <= 8'd0;
      irq_lat_r  <= 8'd0;
      irq_en_r   <= 2'b00;
    end else begin
      prg_size_r <= prg_size_nxt;
      chr_size_r <= chr_size_nxt;
      if (push) begin
        irq_cnt_r <= irq_cnt_nxt;
        irq_lat_r <= irq_lat_nxt;
        irq_en_r  <= irq_en_nxt;
      end
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/cbm_queue.sv
// Two-entry command queue between decoder and page unit.
// Depends on cbm_pkg for cmd_t and the queue depth.
`timescale 1ns / 1ps
`default_nettype none
module cbm_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire cbm_pkg::cmd_t push_cmd,
  input  wire logic          pop,
  output cbm_pkg::cmd_t      pop_cmd,
  output logic               full,
  output logic               empty
);
  import cbm_pkg::*;

  cmd_t            mem_r [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_AW:0]   count_r, count_nxt;

  assign full    = (count_r == (Q_AW+1)'(Q_DEPTH));
  assign empty   = (count_r == '0);
  assign pop_cmd = mem_r[rd_ptr_r];

  // Pointer and fill count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/cbm_back.sv
// Back end: pulls commands, reduces page numbers with a one-bit-per-cycle
// remainder unit, and holds the result word. Depends on cbm_pkg.
`timescale 1ns / 1ps
`default_nettype none
module cbm_back (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire cbm_pkg::cmd_t pop_cmd,
  input  wire logic          q_empty,
  output logic               pop,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic [1:0]         out_update_kind,
  output logic [2:0]         out_slot,
  output logic [7:0]         out_page,
  output logic               out_irq_request
);
  import cbm_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]        state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [VAL_W-1:0]  rem_r, rem_nxt;
  logic [VAL_W-1:0]  quo_r, quo_nxt;
  logic [MOD_W-1:0]  mod_r;
  logic [1:0]        hold_kind_r;
  logic [2:0]        hold_slot_r;
  logic              out_valid_r, out_valid_nxt;
  logic [1:0]        kind_r;
  logic [2:0]        slot_r;
  logic [7:0]        page_r;
  logic              irq_r;
  logic              out_free;
  logic              load_direct;
  logic              load_div;
  logic [VAL_W:0]    trial;
  logic              fits;

  assign out_free    = !out_valid_r || out_ready;
  assign pop         = (state_r == ST_IDLE) && !q_empty && out_free;
  assign load_direct = pop && !pop_cmd.reduce;
  assign load_div    = (state_r == ST_DONE) && out_free;

  // One restoring remainder step: shift in the next dividend bit
  assign trial = {rem_r, quo_r[VAL_W-1]};
  assign fits  = ({{(MOD_W-VAL_W-1){1'b0}}, trial} >= mod_r);

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    rem_nxt       = rem_r;
    quo_nxt       = quo_r;
    out_valid_nxt = out_valid_r;
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      ST_IDLE: begin
        if (pop) begin
          if (pop_cmd.reduce) begin
            state_nxt = ST_DIV;
            step_nxt  = '0;
            rem_nxt   = '0;
            quo_nxt   = pop_cmd.value;
          end else begin
            out_valid_nxt = 1'b1;
          end
        end
      end
      ST_DIV: begin
        if (fits) begin
          rem_nxt = VAL_W'(trial - mod_r[VAL_W:0]);
        end else begin
          rem_nxt = VAL_W'(trial);
        end
        quo_nxt  = {quo_r[VAL_W-2:0], 1'b0};
        step_nxt = step_r + 1'b1;
        if (step_r == {STEP_W{1'b1}}) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt     = ST_IDLE;
          out_valid_nxt = 1'b1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath and result registers
  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    if (pop) begin
      mod_r       <= pop_cmd.modulus;
      hold_kind_r <= pop_cmd.kind;
      hold_slot_r <= pop_cmd.slot;
    end
    if (load_direct) begin
      kind_r <= pop_cmd.kind;
      slot_r <= pop_cmd.slot;
      page_r <= pop_cmd.value;
      irq_r  <= pop_cmd.irq;
    end else if (load_div) begin
      kind_r <= hold_kind_r;
      slot_r <= hold_slot_r;
      page_r <= rem_r;
      irq_r  <= 1'b0;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_update_kind = kind_r;
  assign out_slot        = slot_r;
  assign out_page        = page_r;
  assign out_irq_request = irq_r;

  // A word with no update carries zero slot and page
  a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && kind_r == KIND_NONE) |-> (slot_r == 3'd0 && page_r == 8'd0))
    else $error("idle update carries slot or page");

  // Interrupt only rides on a word with no page update
  a_irq_kind: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && irq_r) |-> (kind_r == KIND_NONE))
    else $error("interrupt on a page update");

  // Remainder unit finishes after its last step
  a_div_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV && step_r == {STEP_W{1'b1}}) |=> (state_r == ST_DONE))
    else $error("remainder unit overran");

  // No new command while the remainder unit is busy
  a_no_pop_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> !pop)
    else $error("command taken while busy");

endmodule
`default_nettype wire

// File: rtl/core/cartridge_bank_mapper_irq_counter.sv
// Top level of the cartridge bank mapper with scanline interrupt counter.
// Instantiates cbm_front, cbm_queue and cbm_back; depends on cbm_pkg.
//
//  channel  | handshake              | payload
//  ---------+------------------------+----------------------------------------
//  in_      | in_valid / in_ready    | in_op, in_addr[15:0], in_data[7:0]
//  out_     | out_valid / out_ready  | out_update_kind, out_slot, out_page,
//           |                        | out_irq_request
//  cfg_     | cfg_valid / cfg_ready  | cfg_index[1:0], cfg_data[7:0]
//
// Ticks, mirroring and interrupt-register words go from the queue straight to the result register.
// Page selections with a nonzero modulus pass the serial remainder unit:
// 8 steps, and it takes no new command until its result has moved on.
// Two words may wait in the queue.
// Synchronous active-low reset; the size registers return to 2 and 0.
// A stalled out_ready holds the result word and backs up into in_ready.
`timescale 1ns / 1ps
`default_nettype none
module cartridge_bank_mapper_irq_counter (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic                          in_op,
  input  wire logic [15:0]                   in_addr,
  input  wire logic [7:0]                    in_data,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [1:0]                         out_update_kind,
  output logic [2:0]                         out_slot,
  output logic [7:0]                         out_page,
  output logic                               out_irq_request,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [cbm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [7:0]                    cfg_data
);
  import cbm_pkg::*;

  logic push;
  logic pop;
  logic q_full;
  logic q_empty;
  cmd_t push_cmd;
  cmd_t pop_cmd;

  // Decoder and interrupt counter
  cbm_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_op     (in_op),
    .in_addr   (in_addr),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_full    (q_full),
    .push      (push),
    .push_cmd  (push_cmd)
  );

  // Command queue
  cbm_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .pop_cmd  (pop_cmd),
    .full     (q_full),
    .empty    (q_empty)
  );

  // Page reduction and result register
  cbm_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .pop_cmd         (pop_cmd),
    .q_empty         (q_empty),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_update_kind (out_update_kind),
    .out_slot        (out_slot),
    .out_page        (out_page),
    .out_irq_request (out_irq_request)
  );

endmodule
`default_nettype wire

// File: dv/cartridge_bank_mapper_irq_counter_tb.sv
// Self-checking testbench for cartridge_bank_mapper_irq_counter.
// Drives bus writes and scanline ticks, decodes each word in a local mapper copy
// and checks every result word in order. Depends on cbm_pkg and the top level.
`timescale 1ns / 1ps
module cartridge_bank_mapper_irq_counter_tb;
  import cbm_pkg::*;

  // Register indexes with no register behind them
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;
  // F002 bit that reloads the counter from the latch
  localparam logic [7:0] IRQ_RELOAD_BIT = 8'h02;
  // Cycles to let pass after the last result word
  localparam int unsigned SETTLE_CYCLES = 24;

  typedef struct packed {
    logic [1:0] kind;
    logic [2:0] slot;
    logic [7:0] page;
    logic       irq;
  } map_update_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic              in_op = OP_WRITE;
  logic [15:0]       in_addr = '0;
  logic [7:0]        in_data = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [1:0]        out_update_kind;
  logic [2:0]        out_slot;
  logic [7:0]        out_page;
  logic              out_irq_request;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [7:0]        cfg_data = '0;

  // Local copy of the mapper state and size registers
  logic [7:0] prg_banks;
  logic [7:0] chr_banks;
  logic [7:0] scan_count;
  logic [7:0] scan_latch;
  logic [1:0] scan_enable;

  map_update_t pending_updates[$];
  int unsigned mismatch_count = 0;
  int unsigned results_seen = 0;
  int unsigned words_sent = 0;
  int unsigned burst_left = 0;
  int unsigned gap_max = 0;

  // Receiver stall pattern
  logic [15:0] ready_pattern = 16'hFFFF;
  logic [5:0]  ready_phase = '0;

  cartridge_bank_mapper_irq_counter u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_op           (in_op),
    .in_addr         (in_addr),
    .in_data         (in_data),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_update_kind (out_update_kind),
    .out_slot        (out_slot),
    .out_page        (out_page),
    .out_irq_request (out_irq_request),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always #1 clk = ~clk;

  // Page number folded into the bank count; zero count leaves it as is
  function automatic logic [7:0] fold_page(input logic [7:0] value, input logic [10:0] banks);
    logic [10:0] rem;
    rem = (banks == '0) ? {3'b000, value} : ({3'b000, value} % banks);
    return rem[7:0];
  endfunction

  // Mapper behavior for one accepted word; updates the local state
  function automatic map_update_t decode_word(input logic op, input logic [15:0] addr,
                                              input logic [7:0] data);
    map_update_t upd;
    logic [6:0] code;
    logic       hi_bank;
    upd = '0;
    code = data[6:0] & MIR_MASK;
    hi_bank = (addr >= ADDR_CHR_HI);
    if (op == OP_TICK) begin
      if (scan_enable != 2'b00) begin
        if (scan_count >= IRQ_LIMIT) begin
          upd.irq = 1'b1;
          scan_count = scan_latch;
          scan_enable = 2'b00;
        end else begin
          scan_count = scan_count + 8'd1;
        end
      end
    end else if (addr == ADDR_PRG0) begin
      upd.kind = KIND_PRG;
      upd.page = fold_page({data[6:0], 1'b0}, {2'b00, prg_banks, 1'b0});
    end else if (addr == ADDR_PRG2) begin
      upd.kind = KIND_PRG;
      upd.slot = 3'd2;
      upd.page = fold_page(data, {2'b00, prg_banks, 1'b0});
    end else if ((addr >= ADDR_CHR_LO && addr <= ADDR_CHR_LOE) ||
                 (addr >= ADDR_CHR_HI && addr <= ADDR_CHR_HIE)) begin
      // slots 1 and 2 swap places within each group of four
      upd.kind = KIND_CHR;
      upd.slot = {hi_bank, addr[0], addr[1]};
      upd.page = fold_page(data, {chr_banks, 3'b000});
    end else if (addr == ADDR_MIRROR) begin
      case (code)
        MIR_CODE_U0, MIR_CODE_U1: begin
          upd.kind = KIND_MIRROR;
          upd.page = MIR_UPPER;
        end
        MIR_CODE_V: begin
          upd.kind = KIND_MIRROR;
          upd.page = MIR_VERT;
        end
        MIR_CODE_H: begin
          upd.kind = KIND_MIRROR;
          upd.page = MIR_HORIZ;
        end
        MIR_CODE_L: begin
          upd.kind = KIND_MIRROR;
          upd.page = MIR_LOWER;
        end
        default: ;
      endcase
    end else if (addr == ADDR_IRQ_LAT) begin
      scan_latch = data;
    end else if (addr == ADDR_IRQ_EN) begin
      scan_enable = {1'b0, data[0]};
    end else if (addr == ADDR_IRQ_CTL) begin
      scan_enable = data[1:0];
      if (data[1]) scan_count = scan_latch;
    end
    return upd;
  endfunction

  task automatic flag_mismatch(input string what);
    $display("[%0t] MISMATCH: %s", $time, what);
    mismatch_count++;
  endtask

  task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
    if (got !== want)
      flag_mismatch($sformatf("result word %0d: %s is %0h, should be %0h",
                              results_seen, name, got, want));
  endtask

  // Send one word; the sender runs in bursts with random gaps between them
  task automatic send_word(input logic op, input logic [15:0] addr, input logic [7:0] data);
    int unsigned gap;
    @(negedge clk);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_op <= op;
    in_addr <= addr;
    in_data <= data;
    do @(posedge clk); while (!in_ready);
    pending_updates.push_back(decode_word(op, addr, data));
    words_sent++;
  endtask

  // Stop sending and wait for every pending result word
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    burst_left = 0;
    while (pending_updates.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_PRG_SIZE: prg_banks = value;
      CFG_CHR_SIZE: chr_banks = value;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_sizes(input logic [7:0] prg, input logic [7:0] chr);
    wait_idle();
    write_reg(CFG_PRG_SIZE, prg);
    write_reg(CFG_CHR_SIZE, chr);
  endtask

  function automatic logic [15:0] pick_page_addr();
    logic [15:0] addr;
    case ($urandom_range(0, 3))
      0: addr = ADDR_PRG0;
      1: addr = ADDR_PRG2;
      2: addr = ADDR_CHR_LO + 16'($urandom_range(0, 3));
      default: addr = ADDR_CHR_HI + 16'($urandom_range(0, 3));
    endcase
    return addr;
  endfunction

  // Mostly known mirroring codes, bit 7 random
  function automatic logic [7:0] pick_mirror_byte();
    logic [6:0] code;
    case ($urandom_range(0, 5))
      0: code = MIR_CODE_U0;
      1: code = MIR_CODE_U1;
      2: code = MIR_CODE_V;
      3: code = MIR_CODE_H;
      4: code = MIR_CODE_L;
      default: code = 7'($urandom);
    endcase
    return {1'($urandom), code};
  endfunction

  // Reset values of the local copy
  task automatic reset_model();
    prg_banks = 8'd2;
    chr_banks = 8'd0;
    scan_count = '0;
    scan_latch = '0;
    scan_enable = '0;
  endtask

  // Receiver: re-pick the stall pattern each time the six-bit phase counter wraps
  always @(negedge clk) begin
    if (ready_phase == '0) begin
      case ($urandom_range(0, 3))
        0: ready_pattern = 16'hFFFF;
        1: ready_pattern = 16'($urandom);
        2: ready_pattern = 16'h0001 << $urandom_range(0, 15);
        default: ready_pattern = 16'($urandom) | 16'($urandom);
      endcase
    end
    out_ready <= ready_pattern[ready_phase[3:0]];
    ready_phase = ready_phase + 6'd1;
  end

  // Result check against the oldest pending update
  always @(posedge clk) begin : result_check
    map_update_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_updates.size() == 0) begin
        flag_mismatch($sformatf("result word %0d with no update pending", results_seen));
      end else begin
        want = pending_updates.pop_front();
        check_field("update_kind", 8'(out_update_kind), 8'(want.kind));
        check_field("slot", 8'(out_slot), 8'(want.slot));
        check_field("page", out_page, want.page);
        check_field("irq_request", 8'(out_irq_request), 8'(want.irq));
      end
      results_seen++;
    end
  end

  // Program and character pages at reset sizes, all eight character slots
  task automatic test_bank_decode();
    send_word(OP_WRITE, ADDR_PRG0, 8'hFF);
    send_word(OP_WRITE, ADDR_PRG2, 8'hFF);
    for (int i = 0; i < 4; i++) begin
      send_word(OP_WRITE, ADDR_CHR_LO + 16'(i), (i % 2 == 0) ? 8'h00 : 8'hFF);
      send_word(OP_WRITE, ADDR_CHR_HI + 16'(i), 8'($urandom));
    end
  endtask

  // Every mirroring code, an unknown code, unmapped address extremes
  task automatic test_mirroring_decode();
    send_word(OP_WRITE, ADDR_MIRROR, {1'b0, MIR_CODE_U0});
    send_word(OP_WRITE, ADDR_MIRROR, {1'b1, MIR_CODE_U1});
    send_word(OP_WRITE, ADDR_MIRROR, {1'b0, MIR_CODE_V});
    send_word(OP_WRITE, ADDR_MIRROR, {1'b1, MIR_CODE_H});
    send_word(OP_WRITE, ADDR_MIRROR, {1'b0, MIR_CODE_L});
    send_word(OP_WRITE, ADDR_MIRROR, {1'b0, MIR_MASK});
    send_word(OP_WRITE, 16'h0000, 8'hFF);
    send_word(OP_WRITE, 16'hFFFF, 8'h00);
  endtask

  // Disabled tick, reload, count to the limit, interrupt, enable via F001
  task automatic test_scanline_irq();
    send_word(OP_TICK, 16'hFFFF, 8'hFF);
    send_word(OP_WRITE, ADDR_IRQ_LAT, IRQ_LIMIT - 8'd1);
    send_word(OP_WRITE, ADDR_IRQ_CTL, 8'hFF);
    repeat (3) send_word(OP_TICK, 16'h0000, 8'h00);
    send_word(OP_WRITE, ADDR_IRQ_EN, 8'hFE);
    send_word(OP_WRITE, ADDR_IRQ_EN, 8'hFF);
    send_word(OP_TICK, ADDR_IRQ_CTL, 8'h00);
  endtask

  // Size extremes, with writes to the unused indexes in between
  task automatic test_size_registers();
    set_sizes(8'd1, 8'd255);
    repeat (40) send_word(OP_WRITE, pick_page_addr(), 8'($urandom));
    set_sizes(8'd255, 8'd0);
    write_reg(CFG_SPARE_LO, 8'hFF);
    write_reg(CFG_SPARE_HI, 8'h00);
    repeat (40) send_word(OP_WRITE, pick_page_addr(), 8'($urandom));
    set_sizes(8'd255, 8'd1);
    repeat (40) send_word(OP_WRITE, pick_page_addr(), 8'($urandom));
    set_sizes(8'd1, 8'd0);
    write_reg(CFG_SPARE_HI, 8'hA5);
    repeat (40) send_word(OP_WRITE, pick_page_addr(), 8'($urandom));
  endtask

  // Latch mostly near the limit, an enable register write, then a run of ticks with a few page writes
  task automatic run_scanline_sequence();
    logic [7:0] latch;
    latch = ($urandom_range(0, 3) != 0) ? 8'($urandom_range(8'hF0, 8'hFF)) : 8'($urandom);
    send_word(OP_WRITE, ADDR_IRQ_LAT, latch);
    case ($urandom_range(0, 3))
      0: send_word(OP_WRITE, ADDR_IRQ_EN, 8'($urandom));
      1: send_word(OP_WRITE, ADDR_IRQ_CTL, 8'($urandom) & ~IRQ_RELOAD_BIT);
      default: send_word(OP_WRITE, ADDR_IRQ_CTL, 8'($urandom) | IRQ_RELOAD_BIT);
    endcase
    repeat ($urandom_range(1, 20)) begin
      if ($urandom_range(0, 7) == 0) send_word(OP_WRITE, pick_page_addr(), 8'($urandom));
      send_word(OP_TICK, 16'($urandom), 8'($urandom));
    end
  endtask

  // Mixed traffic over several size settings and idling levels
  task automatic test_random_traffic(input int unsigned phases, input int unsigned per_phase);
    int unsigned stop_at;
    logic [15:0] addr;
    for (int unsigned p = 0; p < phases; p++) begin
      set_sizes(($urandom_range(0, 1) != 0) ? 8'($urandom_range(1, 8))
                                            : 8'($urandom_range(1, 255)),
                ($urandom_range(0, 2) == 0) ? 8'd0 :
                ($urandom_range(0, 1) != 0) ? 8'($urandom_range(1, 8)) : 8'($urandom));
      if ($urandom_range(0, 2) == 0) write_reg(CFG_SPARE_LO + 2'($urandom_range(0, 1)),
                                               8'($urandom));
      case (p % 3)
        0: gap_max = 0;
        1: gap_max = 3;
        default: gap_max = 12;
      endcase
      stop_at = words_sent + per_phase;
      while (words_sent < stop_at) begin
        case ($urandom_range(0, 19))
          0, 1, 2, 3, 4, 5: run_scanline_sequence();
          6, 7, 8, 9, 10, 11, 12:
            send_word(OP_WRITE, pick_page_addr(), 8'($urandom));
          13, 14: send_word(OP_WRITE, ADDR_MIRROR, pick_mirror_byte());
          15, 16: send_word(OP_TICK, 16'($urandom), 8'($urandom));
          17: send_word(OP_WRITE, ADDR_IRQ_EN, 8'($urandom));
          default: begin
            // random address or a one-bit miss of a mapped one
            addr = ($urandom_range(0, 1) != 0) ? 16'($urandom)
                 : pick_page_addr() ^ (16'h0001 << $urandom_range(0, 15));
            send_word(OP_WRITE, addr, 8'($urandom));
          end
        endcase
      end
    end
    gap_max = 4;
  endtask

  initial begin
    reset_model();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    gap_max = 4;
    test_bank_decode();
    test_mirroring_decode();
    test_scanline_irq();
    test_size_registers();
    test_random_traffic(6, 280);
    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0)
      $display("cartridge_bank_mapper_irq_counter_tb: done, clean");
    else
      $display("cartridge_bank_mapper_irq_counter_tb: done, errors");
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("[%0t] timeout, %0d result words pending", $time, pending_updates.size());
    $display("cartridge_bank_mapper_irq_counter_tb: done, errors");
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/cbm_pkg.sv
rtl/core/cbm_front.sv
rtl/core/cbm_queue.sv
rtl/core/cbm_back.sv
rtl/core/cartridge_bank_mapper_irq_counter.sv
dv/cartridge_bank_mapper_irq_counter_tb.sv
